// ===== src/swce_pkg.sv =====
// Shared types, register indexes and saturating helpers for the waypoint cost unit.
package swce_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_X_LINE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LINE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_H_LINE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SHAPE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SHAPE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_H_SHAPE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICE_MAP = 3'd6;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  // Per-axis terms handed from a lane to the summing stages.
  typedef struct packed {
    logic        ok;
    logic [63:0] cost;
    logic [63:0] slope;
    logic [63:0] curv;
  } axis_term_t;

  // Unsigned 128 -> 64 with saturation.
  function automatic logic [63:0] sat_u64(input logic [127:0] x);
    return (x[127:64] != 64'd0) ? '1 : x[63:0];
  endfunction

  // Magnitude plus sign -> saturated signed 64.
  function automatic logic [63:0] make_s64(input logic [63:0] m, input logic neg);
    logic [63:0] r;
    if (neg) begin
      r = m[63] ? S64_MIN : (~m + 64'd1);
    end else begin
      r = m[63] ? S64_MAX : m;
    end
    return r;
  endfunction

  function automatic logic [63:0] sadd64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    logic [63:0] r;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      r = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

endpackage

// ===== src/swce_mul.sv =====
// Two-stage 64x64 unsigned multiplier built from four 32x32 partial products.
module swce_mul #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [127:0]      prod,
  output logic [SIDE_W-1:0] out_side
);

  logic [63:0]       pp_ll, pp_lh, pp_hl, pp_hh;
  logic              v1;
  logic [SIDE_W-1:0] side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_ll    <= a[31:0] * b[31:0];
      pp_lh    <= a[31:0] * b[63:32];
      pp_hl    <= a[63:32] * b[31:0];
      pp_hh    <= a[63:32] * b[63:32];
      side1    <= in_side;
      prod     <= {pp_hh, 64'd0} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
                + {64'd0, pp_ll};
      out_side <= side1;
    end
  end

endmodule

// ===== src/swce_div.sv =====
// Pipelined restoring divider: 128-bit numerator by 64-bit divisor, saturated 64-bit quotient.
module swce_div #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [127:0]      num,
  input  logic [63:0]       den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [63:0]       quo,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = 64;

  logic [63:0]       rem_q  [0:STEPS];
  logic [63:0]       low_q  [0:STEPS];
  logic [63:0]       quo_q  [0:STEPS];
  logic [63:0]       den_q  [0:STEPS];
  logic              big_q  [0:STEPS];
  logic              v_q    [0:STEPS];
  logic [SIDE_W-1:0] side_q [0:STEPS];

  logic [64:0] trial [0:STEPS-1];
  logic [64:0] diff  [0:STEPS-1];
  logic        take  [0:STEPS-1];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      trial[k] = {rem_q[k], low_q[k][63]};
      diff[k]  = trial[k] - {1'b0, den_q[k]};
      take[k]  = (trial[k] >= {1'b0, den_q[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
      for (int k = 0; k < STEPS; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // quotient overflows 64 bits when the upper numerator half reaches the divisor
      big_q[0]  <= (num[127:64] >= den);
      rem_q[0]  <= num[127:64];
      low_q[0]  <= num[63:0];
      quo_q[0]  <= 64'd0;
      den_q[0]  <= den;
      side_q[0] <= in_side;
      for (int k = 0; k < STEPS; k++) begin
        rem_q[k+1]  <= take[k] ? diff[k][63:0] : trial[k][63:0];
        low_q[k+1]  <= {low_q[k][62:0], 1'b0};
        quo_q[k+1]  <= {quo_q[k][62:0], take[k]};
        den_q[k+1]  <= den_q[k];
        big_q[k+1]  <= big_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = v_q[STEPS];
  assign quo       = big_q[STEPS] ? '1 : quo_q[STEPS];
  assign out_side  = side_q[STEPS];

endmodule

// ===== src/swce_sqrt.sv =====
// Pipelined integer square root of a 128-bit radicand, one root bit per stage.
module swce_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [127:0]      rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [63:0]       root,
  output logic [SIDE_W-1:0] out_side
);

  localparam int STEPS = 64;

  logic [65:0]       rem_q  [0:STEPS];
  logic [63:0]       root_q [0:STEPS];
  logic [127:0]      rad_q  [0:STEPS];
  logic              v_q    [0:STEPS];
  logic [SIDE_W-1:0] side_q [0:STEPS];

  logic [67:0] cur   [0:STEPS-1];
  logic [67:0] trial [0:STEPS-1];
  logic [67:0] diff  [0:STEPS-1];
  logic        take  [0:STEPS-1];

  always_comb begin
    for (int k = 0; k < STEPS; k++) begin
      cur[k]   = {rem_q[k], rad_q[k][127:126]};
      trial[k] = {2'b00, root_q[k], 2'b01};
      diff[k]  = cur[k] - trial[k];
      take[k]  = (cur[k] >= trial[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= STEPS; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid;
      for (int k = 0; k < STEPS; k++) v_q[k+1] <= v_q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0]  <= 66'd0;
      root_q[0] <= 64'd0;
      rad_q[0]  <= rad;
      side_q[0] <= in_side;
      for (int k = 0; k < STEPS; k++) begin
        rem_q[k+1]  <= take[k] ? diff[k][65:0] : cur[k][65:0];
        root_q[k+1] <= {root_q[k][62:0], take[k]};
        rad_q[k+1]  <= {rad_q[k][125:0], 2'b00};
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign out_valid = v_q[STEPS];
  assign root      = root_q[STEPS];
  assign out_side  = side_q[STEPS];

endmodule

// ===== src/swce_axis.sv =====
// One axis lane: error, smoothed root, cost term and its two derivative terms.
module swce_axis #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [63:0]             lam,
  input  logic [63:0]             line,
  input  logic [63:0]             shape,
  output logic                    out_valid,
  output swce_pkg::axis_term_t    term
);
  import swce_pkg::*;

  localparam int LINE_SH = 32 - FRAC_BITS;
  localparam int EPS_SH  = 64 - FRAC_BITS;

  // Config-derived; user changes registers only while block empty; unenforced.
  logic [63:0]  a_val, b_val, b_mag, w_val;
  logic         b_neg;
  logic [127:0] eps_w, b_sh;

  assign a_val = {{32{line[63]}}, line[63:32]} << LINE_SH;
  assign b_val = {{32{line[31]}}, line[31:0]} << LINE_SH;
  assign b_neg = line[31];
  assign b_mag = abs64(b_val);
  assign w_val = {32'd0, shape[63:32]};
  assign eps_w = {96'd0, shape[31:0]} << EPS_SH;
  assign b_sh  = {64'd0, b_mag} << 32;

  // lambda * slope
  logic         m1_v;
  logic [127:0] m1_p;
  logic         m1_s;

  swce_mul #(.SIDE_W(1)) u_mul_lb (
    .clk, .rst, .en,
    .in_valid (in_valid), .a(abs64(lam)), .b(b_mag), .in_side(lam[63]),
    .out_valid(m1_v), .prod(m1_p), .out_side(m1_s)
  );

  // error e = A - lambda*B, three short stages
  logic        e1_v, e2_v, e3_v;
  logic [63:0] nlb, e_val, em;
  logic        eneg;
  logic [63:0] lb_mag, lb_clip;
  logic        lb_neg;

  assign lb_mag  = sat_u64({32'd0, m1_p[127:32]});
  assign lb_clip = lb_mag[63] ? S64_MAX : lb_mag;
  assign lb_neg  = m1_s != b_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_v <= 1'b0;
      e2_v <= 1'b0;
      e3_v <= 1'b0;
    end else if (en) begin
      e1_v <= m1_v;
      e2_v <= e1_v;
      e3_v <= e2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nlb   <= lb_neg ? lb_clip : (~lb_clip + 64'd1);
      e_val <= sadd64(a_val, nlb);
      em    <= abs64(e_val);
      eneg  <= e_val[63];
    end
  end

  // e^2 then radicand
  logic         m2_v;
  logic [127:0] m2_p;
  logic [64:0]  m2_s;
  logic         r_v;
  logic [127:0] rad;
  logic [64:0]  r_s;

  swce_mul #(.SIDE_W(65)) u_mul_sq (
    .clk, .rst, .en,
    .in_valid (e3_v), .a(em), .b(em), .in_side({eneg, em}),
    .out_valid(m2_v), .prod(m2_p), .out_side(m2_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v <= 1'b0;
    end else if (en) begin
      r_v <= m2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad <= m2_p + eps_w;
      r_s <= m2_s;
    end
  end

  logic        q_v;
  logic [63:0] root;
  logic [64:0] q_s;

  swce_sqrt #(.SIDE_W(65)) u_sqrt (
    .clk, .rst, .en,
    .in_valid (r_v), .rad(rad), .in_side(r_s),
    .out_valid(q_v), .root(root), .out_side(q_s)
  );

  // w*root and |B|*|e|
  logic         ma_v;
  logic [127:0] ma_p, mb_p;
  logic [64:0]  ma_s;

  swce_mul #(.SIDE_W(65)) u_mul_cost (
    .clk, .rst, .en,
    .in_valid (q_v), .a(w_val), .b(root), .in_side({q_s[64], root}),
    .out_valid(ma_v), .prod(ma_p), .out_side(ma_s)
  );

  swce_mul #(.SIDE_W(1)) u_mul_be (
    .clk, .rst, .en,
    .in_valid (q_v), .a(b_mag), .b(q_s[63:0]), .in_side(1'b0),
    .out_valid(), .prod(mb_p), .out_side()
  );

  logic         c_v, c_ok, c_sneg;
  logic [63:0]  c_cost, c_root;
  logic [127:0] c_bem;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_v <= 1'b0;
    end else if (en) begin
      c_v <= ma_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_cost <= make_s64(sat_u64(ma_p >> FRAC_BITS), 1'b0);
      c_ok   <= (ma_s[63:0] != 64'd0);
      c_sneg <= (b_neg == ma_s[64]);
      c_root <= ma_s[63:0];
      c_bem  <= mb_p;
    end
  end

  // three quotients by the root
  logic        d_v;
  logic [63:0] t_q, u_q, v_q;
  logic [65:0] d_s;

  swce_div #(.SIDE_W(66)) u_div_t (
    .clk, .rst, .en,
    .in_valid (c_v), .num(c_bem), .den(c_root), .in_side({c_sneg, c_ok, c_cost}),
    .out_valid(d_v), .quo(t_q), .out_side(d_s)
  );

  swce_div #(.SIDE_W(1)) u_div_u (
    .clk, .rst, .en,
    .in_valid (c_v), .num(b_sh), .den(c_root), .in_side(1'b0),
    .out_valid(), .quo(u_q), .out_side()
  );

  swce_div #(.SIDE_W(1)) u_div_v (
    .clk, .rst, .en,
    .in_valid (c_v), .num(eps_w), .den(c_root), .in_side(1'b0),
    .out_valid(), .quo(v_q), .out_side()
  );

  // u^2 and w*t
  logic          mc_v;
  logic [127:0]  mc_p, md_p;
  logic [129:0]  mc_s;

  swce_mul #(.SIDE_W(130)) u_mul_uu (
    .clk, .rst, .en,
    .in_valid (d_v), .a(u_q), .b(u_q), .in_side({v_q, d_s}),
    .out_valid(mc_v), .prod(mc_p), .out_side(mc_s)
  );

  swce_mul #(.SIDE_W(1)) u_mul_wt (
    .clk, .rst, .en,
    .in_valid (d_v), .a(w_val), .b(t_q), .in_side(1'b0),
    .out_valid(), .prod(md_p), .out_side()
  );

  logic        s_v, s_ok;
  logic [63:0] s_u2, s_v2, s_cost, s_slope;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_v <= 1'b0;
    end else if (en) begin
      s_v <= mc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_u2    <= sat_u64({32'd0, mc_p[127:32]});
      s_v2    <= mc_s[129:66];
      s_cost  <= mc_s[63:0];
      s_ok    <= mc_s[64];
      s_slope <= make_s64(sat_u64(md_p >> FRAC_BITS), mc_s[65]);
    end
  end

  // (u^2 * v) then times weight
  logic         me_v;
  logic [127:0] me_p;
  logic [128:0] me_s;
  logic         k_v;
  logic [63:0]  k_t2;
  logic [128:0] k_s;
  logic         mf_v;
  logic [127:0] mf_p;
  logic [128:0] mf_s;

  swce_mul #(.SIDE_W(129)) u_mul_uv (
    .clk, .rst, .en,
    .in_valid (s_v), .a(s_u2), .b(s_v2), .in_side({s_ok, s_slope, s_cost}),
    .out_valid(me_v), .prod(me_p), .out_side(me_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (en) begin
      k_v <= me_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_t2 <= sat_u64({32'd0, me_p[127:32]});
      k_s  <= me_s;
    end
  end

  swce_mul #(.SIDE_W(129)) u_mul_wk (
    .clk, .rst, .en,
    .in_valid (k_v), .a(w_val), .b(k_t2), .in_side(k_s),
    .out_valid(mf_v), .prod(mf_p), .out_side(mf_s)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= mf_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term.ok    <= mf_s[128];
      term.slope <= mf_s[127:64];
      term.cost  <= mf_s[63:0];
      term.curv  <= make_s64(sat_u64(mf_p >> FRAC_BITS), 1'b0);
    end
  end

endmodule

// ===== src/smoothed_waypoint_cost_eval_unit.sv =====
// Top level of the smoothed waypoint cost unit: config, lambda, three axis lanes, summing.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata[31:0]  param_value
//  m_*     | out | m_tvalid/m_tready  | m_tdata cost/slope/curvature, m_tuser invalid
//  cfg_*   | in  | cfg_we             | cfg_addr register index, cfg_wdata value
//
// One request per cycle while the output is not held; the path runs through three 64-step
// dividers (65 stages each) and the 65-stage root in series (lambda,
// root, quotients, final scale).
// The whole pipeline advances together while the output register is empty or taken;
// a held result freezes every stage, so nothing is dropped or repeated.
// rst (synchronous) clears the config registers and every valid bit.
module smoothed_waypoint_cost_eval_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,    // [31:0] param_value
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,    // [63:0] cost_value, [127:64] cost_slope,
                                   // [191:128] cost_curvature
  output logic [0:0]   m_tuser,    // [0] invalid
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);
  import swce_pkg::*;

  logic en;
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;

  // Config registers, indexes beyond the slice map are dropped
  logic [63:0] cfg_q [0:6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= 6; i++) cfg_q[i] <= 64'd0;
    end else if (cfg_we && cfg_addr <= CFG_SLICE_MAP) begin
      cfg_q[cfg_addr] <= cfg_wdata;
    end
  end

  logic [31:0] g_val, c_val, g_mag;
  logic        g_neg, g_zero;
  logic [63:0] gm, gm_sq;

  assign g_val  = cfg_q[CFG_SLICE_MAP][31:0];
  assign c_val  = cfg_q[CFG_SLICE_MAP][63:32];
  assign g_neg  = g_val[31];
  assign g_zero = (g_val == 32'd0);
  assign g_mag  = g_neg ? (~g_val + 32'd1) : g_val;
  assign gm     = {32'd0, g_mag};

  // g^2 follows config; settled long before any request reaches the curvature divide
  always_ff @(posedge clk) begin
    gm_sq <= g_mag * g_mag;
  end

  // Front: d = p - c, then |d| aligned to Q32
  logic         t1_v, t2_v;
  logic [32:0]  d_val;
  logic [127:0] lam_num;
  logic         lam_sgn;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else if (en) begin
      t1_v <= s_tvalid;
      t2_v <= t1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_val   <= {s_tdata[31], s_tdata} - {c_val[31], c_val};
      lam_num <= {63'd0, (d_val[32] ? (~d_val + 33'd1) : d_val), 32'd0};
      lam_sgn <= d_val[32] != g_neg;
    end
  end

  logic        dl_v, dl_s;
  logic [63:0] dl_q;

  swce_div #(.SIDE_W(1)) u_div_lam (
    .clk, .rst, .en,
    .in_valid (t2_v), .num(lam_num), .den(gm), .in_side(lam_sgn),
    .out_valid(dl_v), .quo(dl_q), .out_side(dl_s)
  );

  logic        t3_v;
  logic [63:0] lam;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else if (en) begin
      t3_v <= dl_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lam <= make_s64(dl_q, dl_s);
    end
  end

  // Axis lanes run in lockstep; the x lane's valid stands for all three
  logic       ax_v;
  axis_term_t tx, ty, th;

  swce_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
    .clk, .rst, .en, .in_valid(t3_v), .lam(lam),
    .line(cfg_q[CFG_X_LINE]), .shape(cfg_q[CFG_X_SHAPE]),
    .out_valid(ax_v), .term(tx)
  );

  swce_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
    .clk, .rst, .en, .in_valid(t3_v), .lam(lam),
    .line(cfg_q[CFG_Y_LINE]), .shape(cfg_q[CFG_Y_SHAPE]),
    .out_valid(), .term(ty)
  );

  swce_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_h (
    .clk, .rst, .en, .in_valid(t3_v), .lam(lam),
    .line(cfg_q[CFG_H_LINE]), .shape(cfg_q[CFG_H_SHAPE]),
    .out_valid(), .term(th)
  );

  // Saturating sums in x, y, heading order
  logic         s1_v, s2_v, s3_v;
  logic [63:0]  c_xy, sl_xy, k_xy;
  axis_term_t   h_d;
  logic         ok1, ok2, ok3;
  logic [63:0]  c_sum, sl_sum, k_sum, c3;
  logic [127:0] sl_num, k_num;
  logic         sl_neg, k_neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
    end else if (en) begin
      s1_v <= ax_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_xy   <= sadd64(tx.cost, ty.cost);
      sl_xy  <= sadd64(tx.slope, ty.slope);
      k_xy   <= sadd64(tx.curv, ty.curv);
      h_d    <= th;
      ok1    <= tx.ok & ty.ok & th.ok;
      c_sum  <= sadd64(c_xy, h_d.cost);
      sl_sum <= sadd64(sl_xy, h_d.slope);
      k_sum  <= sadd64(k_xy, h_d.curv);
      ok2    <= ok1;
      // scale back from lambda to parameter units
      sl_num <= {64'd0, abs64(sl_sum)} << FRAC_BITS;
      k_num  <= {64'd0, abs64(k_sum)} << (2 * FRAC_BITS);
      sl_neg <= sl_sum[63] != g_neg;
      k_neg  <= k_sum[63];
      c3     <= c_sum;
      ok3    <= ok2;
    end
  end

  logic        ds_v;
  logic [63:0] qs, qk;
  logic [66:0] ds_s;

  swce_div #(.SIDE_W(67)) u_div_slope (
    .clk, .rst, .en,
    .in_valid (s3_v), .num(sl_num), .den(gm), .in_side({k_neg, sl_neg, ok3, c3}),
    .out_valid(ds_v), .quo(qs), .out_side(ds_s)
  );

  swce_div #(.SIDE_W(1)) u_div_curv (
    .clk, .rst, .en,
    .in_valid (s3_v), .num(k_num), .den(gm_sq), .in_side(1'b0),
    .out_valid(), .quo(qk), .out_side()
  );

  // Output register; a zero generator or zero root forces zeros and the flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= ds_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (g_zero || !ds_s[64]) begin
        m_tdata <= '0;
        m_tuser <= 1'b1;
      end else begin
        m_tdata <= {make_s64(qk, ds_s[66]), make_s64(qs, ds_s[65]), ds_s[63:0]};
        m_tuser <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("flagged result carries nonzero data");

  a_nonneg: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[63] && !m_tdata[191])
    else $error("cost or curvature negative");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule
